/* hdl/tapc_pkg.sv */
// Shared types, register codes and blend arithmetic for the tinted alpha pixel compositor.
// No dependencies; the files that use it refer to it by scoped names.
package tapc_pkg;

	localparam int CH_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 8;
	localparam int MIX_W = 2 * CH_W;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_TINT_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_RED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TINT_ALPHA  = 3'd4;

	typedef logic [CH_W-1:0] chan_t;
	typedef logic [MIX_W-1:0] mix_t;

	typedef struct packed {
		chan_t r;
		chan_t g;
		chan_t b;
		chan_t a;
	} pixel_t;

	typedef struct packed {
		logic   enable;
		pixel_t color;
	} tint_cfg_t;

	// bg*(255-wa) + fg*wa, at most 255*255 so it fits 16 bits
	function automatic mix_t mix_sum(chan_t bg, chan_t fg, chan_t wa);
		mix_t p_bg;
		mix_t p_fg;
		p_bg = MIX_W'(bg) * MIX_W'(CH_MAX - wa);
		p_fg = MIX_W'(fg) * MIX_W'(wa);
		return p_bg + p_fg;
	endfunction

	// floor(x/255), exact for x up to 255*255
	function automatic chan_t div255(mix_t x);
		logic [MIX_W:0] t;
		t = (MIX_W+1)'(x) + (MIX_W+1)'(x[MIX_W-1:CH_W]) + (MIX_W+1)'(1);
		return t[MIX_W-1:CH_W];
	endfunction

	function automatic chan_t sat_add(chan_t a, chan_t b);
		logic [CH_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CH_W] ? CH_MAX : s[CH_W-1:0];
	endfunction

endpackage

/* hdl/tapc_ifs.sv */
// Pixel stream interfaces: source+destination pixel in, blended pixel out.
// Depends on tapc_pkg for the channel type.
interface tapc_pix_in_if;
	logic valid;
	logic ready;
	tapc_pkg::chan_t src_red;
	tapc_pkg::chan_t src_green;
	tapc_pkg::chan_t src_blue;
	tapc_pkg::chan_t src_alpha;
	tapc_pkg::chan_t dest_red;
	tapc_pkg::chan_t dest_green;
	tapc_pkg::chan_t dest_blue;
	tapc_pkg::chan_t dest_alpha;

	modport source(output valid, src_red, src_green, src_blue, src_alpha,
		dest_red, dest_green, dest_blue, dest_alpha, input ready);
	modport sink(input valid, src_red, src_green, src_blue, src_alpha,
		dest_red, dest_green, dest_blue, dest_alpha, output ready);
endinterface

interface tapc_pix_out_if;
	logic valid;
	logic ready;
	tapc_pkg::chan_t out_red;
	tapc_pkg::chan_t out_green;
	tapc_pkg::chan_t out_blue;
	tapc_pkg::chan_t out_alpha;

	modport source(output valid, out_red, out_green, out_blue, out_alpha, input ready);
	modport sink(input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

/* hdl/tapc_cfg.sv */
// Tint configuration registers behind a plain write port.
// Depends on tapc_pkg.
module tapc_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [tapc_pkg::CFG_IDX_W-1:0]  index,
	input  logic [tapc_pkg::CFG_DATA_W-1:0] wdata,
	output tapc_pkg::tint_cfg_t             cfg
);

	tapc_pkg::tint_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			case (index)
				tapc_pkg::REG_TINT_ENABLE: cfg_q.enable <= wdata[0];
				tapc_pkg::REG_TINT_RED:    cfg_q.color.r <= wdata;
				tapc_pkg::REG_TINT_GREEN:  cfg_q.color.g <= wdata;
				tapc_pkg::REG_TINT_BLUE:   cfg_q.color.b <= wdata;
				tapc_pkg::REG_TINT_ALPHA:  cfg_q.color.a <= wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/tapc_tint.sv */
// Stages 1-2: blend tint over source (weighted sums, then /255) if enabled and
// src alpha nonzero, else pass src; needs tapc_pkg; dst rides along unchanged.
module tapc_tint (
	input  logic                clk,
	input  logic                arst_n,
	input  tapc_pkg::tint_cfg_t cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  tapc_pkg::pixel_t    src,
	input  tapc_pkg::pixel_t    dst,
	output logic                out_valid,
	input  logic                out_ready,
	output tapc_pkg::pixel_t    fg,
	output tapc_pkg::pixel_t    dst_out
);

	logic             v_s1, v_s2;
	logic             rdy_s1, rdy_s2;
	logic             apply_s1;
	tapc_pkg::mix_t   mix_r_s1, mix_g_s1, mix_b_s1;
	tapc_pkg::chan_t  tint_a_s1;
	tapc_pkg::pixel_t src_s1, dst_s1;
	tapc_pkg::pixel_t fg_s2, dst_s2;

	assign rdy_s2   = !v_s2 || out_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			// transparent source skips the tint
			apply_s1  <= cfg.enable && (src.a != '0);
			mix_r_s1  <= tapc_pkg::mix_sum(src.r, cfg.color.r, cfg.color.a);
			mix_g_s1  <= tapc_pkg::mix_sum(src.g, cfg.color.g, cfg.color.a);
			mix_b_s1  <= tapc_pkg::mix_sum(src.b, cfg.color.b, cfg.color.a);
			tint_a_s1 <= tapc_pkg::sat_add(src.a, cfg.color.a);
			src_s1    <= src;
			dst_s1    <= dst;
		end
		if (rdy_s2 && v_s1) begin
			if (apply_s1) begin
				fg_s2.r <= tapc_pkg::div255(mix_r_s1);
				fg_s2.g <= tapc_pkg::div255(mix_g_s1);
				fg_s2.b <= tapc_pkg::div255(mix_b_s1);
				fg_s2.a <= tint_a_s1;
			end else begin
				fg_s2 <= src_s1;
			end
			dst_s2 <= dst_s1;
		end
	end

	assign out_valid = v_s2;
	assign fg        = fg_s2;
	assign dst_out   = dst_s2;

endmodule

/* hdl/tapc_over.sv */
// Stages 3-4: blend the (tinted) source over the destination, /255, saturated alpha.
// Depends on tapc_pkg; stage 4 is the output register.
module tapc_over (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  tapc_pkg::pixel_t fg,
	input  tapc_pkg::pixel_t dst,
	output logic             out_valid,
	input  logic             out_ready,
	output tapc_pkg::pixel_t res
);

	logic             v_s3, v_s4;
	logic             rdy_s3, rdy_s4;
	tapc_pkg::mix_t   mix_r_s3, mix_g_s3, mix_b_s3;
	tapc_pkg::chan_t  alpha_s3;
	tapc_pkg::pixel_t res_s4;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3) v_s3 <= in_valid;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			mix_r_s3 <= tapc_pkg::mix_sum(dst.r, fg.r, fg.a);
			mix_g_s3 <= tapc_pkg::mix_sum(dst.g, fg.g, fg.a);
			mix_b_s3 <= tapc_pkg::mix_sum(dst.b, fg.b, fg.a);
			alpha_s3 <= tapc_pkg::sat_add(dst.a, fg.a);
		end
		if (rdy_s4 && v_s3) begin
			res_s4.r <= tapc_pkg::div255(mix_r_s3);
			res_s4.g <= tapc_pkg::div255(mix_g_s3);
			res_s4.b <= tapc_pkg::div255(mix_b_s3);
			res_s4.a <= alpha_s3;
		end
	end

	assign out_valid = v_s4;
	assign res       = res_s4;

endmodule

/* hdl/tinted_alpha_pixel_compositor.sv */
// Tinted alpha pixel compositor: 4-stage pipeline, one pixel word per cycle unless
// the output stalls. An accepted word moves through the registered stages in order:
// multiply (s1), /255 (s2), multiply (s3) and /255 (s4), whose register is the output.
// Every stage holds under back-pressure, so a stalled output still lets bubbles fill.
// arst_n clears all stage valid bits and the tint registers (tint off, color 0).
// Depends on tapc_pkg, tapc_ifs, tapc_cfg, tapc_tint, tapc_over.
module tinted_alpha_pixel_compositor (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tapc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tapc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	tapc_pix_in_if.sink                     pix_in,
	tapc_pix_out_if.source                  pix_out
);

	tapc_pkg::tint_cfg_t cfg;
	tapc_pkg::pixel_t    src, dst, fg, dst_mid, res;
	logic                mid_valid, mid_ready;

	tapc_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.wdata  (cfg_wdata),
		.cfg    (cfg)
	);

	assign src = '{r: pix_in.src_red, g: pix_in.src_green,
		b: pix_in.src_blue, a: pix_in.src_alpha};
	assign dst = '{r: pix_in.dest_red, g: pix_in.dest_green,
		b: pix_in.dest_blue, a: pix_in.dest_alpha};

	tapc_tint u_tint (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.src       (src),
		.dst       (dst),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.fg        (fg),
		.dst_out   (dst_mid)
	);

	tapc_over u_over (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.fg        (fg),
		.dst       (dst_mid),
		.out_valid (pix_out.valid),
		.out_ready (pix_out.ready),
		.res       (res)
	);

	assign pix_out.out_red   = res.r;
	assign pix_out.out_green = res.g;
	assign pix_out.out_blue  = res.b;
	assign pix_out.out_alpha = res.a;

endmodule

/* hdl/tapc_checker.sv */
// Port-level checks for the compositor, bound to the top level.
// Depends on tinted_alpha_pixel_compositor and the pixel interfaces.
module tapc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] out_data
);

	// a held word keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// with the sink ready throughout, the output is valid once an accepted word has passed every stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready ##1 out_ready ##1 out_ready ##1 out_ready |=> out_valid)
		else $error("accepted word did not reach the output in time");

	// the pipe is flushed by the first edge seen in reset at the latest
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("output valid during reset");

endmodule

bind tinted_alpha_pixel_compositor tapc_checker u_tapc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pix_in.valid),
	.in_ready  (pix_in.ready),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_data  ({pix_out.out_red, pix_out.out_green, pix_out.out_blue, pix_out.out_alpha})
);

/* tb/tapc_blend_checker.sv */
// Checker for the tinted alpha pixel compositor: snoops the register port and both
// pixel streams, predicts each blended word and compares it. Needs tapc_pkg, tapc_ifs.
module tapc_blend_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tapc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tapc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	tapc_pix_in_if                           pix_in,
	tapc_pix_out_if                          pix_out,
	output int                               fail_count,
	output int                               outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FULL = 255;

	logic             tint_on;
	tapc_pkg::pixel_t tint_color;
	tapc_pkg::pixel_t expected_pixels[$];
	int               errors = 0;

	assign fail_count = errors;

	function automatic tapc_pkg::chan_t mix_chan(tapc_pkg::chan_t bg, tapc_pkg::chan_t fg,
			tapc_pkg::chan_t wa);
		int unsigned acc;
		acc = int'(bg) * (FULL - int'(wa)) + int'(fg) * int'(wa);
		return tapc_pkg::chan_t'(acc / FULL);
	endfunction

	// non-premultiplied "fg over bg", alpha sum saturates
	function automatic tapc_pkg::pixel_t over(tapc_pkg::pixel_t bg, tapc_pkg::pixel_t fg);
		tapc_pkg::pixel_t res;
		int unsigned      asum;
		res.r = mix_chan(bg.r, fg.r, fg.a);
		res.g = mix_chan(bg.g, fg.g, fg.a);
		res.b = mix_chan(bg.b, fg.b, fg.a);
		asum = int'(bg.a) + int'(fg.a);
		res.a = (asum > FULL) ? tapc_pkg::chan_t'(FULL) : tapc_pkg::chan_t'(asum);
		return res;
	endfunction

	function automatic tapc_pkg::pixel_t composite_pixel(tapc_pkg::pixel_t src,
			tapc_pkg::pixel_t dst);
		tapc_pkg::pixel_t fg;
		// tint is skipped on a fully transparent source
		fg = (tint_on && src.a != '0) ? over(src, tint_color) : src;
		return over(dst, fg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tapc_pkg::pixel_t src_px;
		tapc_pkg::pixel_t dst_px;
		tapc_pkg::pixel_t got;
		tapc_pkg::pixel_t want;
		if (!arst_n) begin
			tint_on <= 1'b0;
			tint_color <= '0;
			expected_pixels.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tapc_pkg::REG_TINT_ENABLE: tint_on <= cfg_wdata[0];
					tapc_pkg::REG_TINT_RED:    tint_color.r <= cfg_wdata[tapc_pkg::CH_W-1:0];
					tapc_pkg::REG_TINT_GREEN:  tint_color.g <= cfg_wdata[tapc_pkg::CH_W-1:0];
					tapc_pkg::REG_TINT_BLUE:   tint_color.b <= cfg_wdata[tapc_pkg::CH_W-1:0];
					tapc_pkg::REG_TINT_ALPHA:  tint_color.a <= cfg_wdata[tapc_pkg::CH_W-1:0];
					default: ;
				endcase
			end
			if (pix_in.valid && pix_in.ready) begin
				src_px = {pix_in.src_red, pix_in.src_green, pix_in.src_blue, pix_in.src_alpha};
				dst_px = {pix_in.dest_red, pix_in.dest_green, pix_in.dest_blue,
					pix_in.dest_alpha};
				expected_pixels = {expected_pixels, composite_pixel(src_px, dst_px)};
			end
			if (pix_out.valid && pix_out.ready) begin
				got = {pix_out.out_red, pix_out.out_green, pix_out.out_blue,
					pix_out.out_alpha};
				if (expected_pixels.size() == 0) begin
					if (errors < 10)
						$display("%0t: output word with nothing expected: %0d %0d %0d %0d",
							$realtime, got.r, got.g, got.b, got.a);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					if (got.r !== want.r || got.g !== want.g || got.b !== want.b
							|| got.a !== want.a) begin
						if (errors < 10)
							$display("%0t: mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
								$realtime, want.r, want.g, want.b, want.a,
								got.r, got.g, got.b, got.a);
						errors++;
					end
				end
			end
			outstanding <= expected_pixels.size();
		end
	end

endmodule

/* tb/tb.sv */
// Top of the compositor bench: clock, reset, register writes, pixel stimulus and
// random output stalls. Needs tapc_pkg, tapc_ifs, tapc_blend_checker and the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 300000;
	localparam int PHASES = 10;
	localparam int WORDS_PER_PHASE = 95;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we;
	logic [tapc_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tapc_pkg::CFG_DATA_W-1:0] cfg_wdata;
	logic                            calm = 1'b0;
	int                              fail_count;
	int                              outstanding;
	int                              cycles = 0;

	tapc_pix_in_if  pix_in();
	tapc_pix_out_if pix_out();

	tinted_alpha_pixel_compositor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pix_in   (pix_in),
		.pix_out  (pix_out)
	);

	tapc_blend_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pix_in     (pix_in),
		.pix_out    (pix_out),
		.fail_count (fail_count),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic tapc_pkg::pixel_t pix(int r, int g, int b, int a);
		return {tapc_pkg::chan_t'(r), tapc_pkg::chan_t'(g), tapc_pkg::chan_t'(b),
			tapc_pkg::chan_t'(a)};
	endfunction

	// extremes show up often so alpha 0 and 255 get real coverage
	function automatic tapc_pkg::chan_t rand_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return tapc_pkg::chan_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic tapc_pkg::pixel_t rand_pixel();
		return {rand_chan(), rand_chan(), rand_chan(), rand_chan()};
	endfunction

	task automatic write_reg(logic [tapc_pkg::CFG_IDX_W-1:0] idx,
			logic [tapc_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
	endtask

	// enable takes a full byte on purpose: only bit 0 counts
	task automatic load_tint(logic [tapc_pkg::CFG_DATA_W-1:0] enable,
			tapc_pkg::pixel_t color, bit junk);
		write_reg(tapc_pkg::REG_TINT_ENABLE, enable);
		write_reg(tapc_pkg::REG_TINT_RED, color.r);
		write_reg(tapc_pkg::REG_TINT_GREEN, color.g);
		write_reg(tapc_pkg::REG_TINT_BLUE, color.b);
		write_reg(tapc_pkg::REG_TINT_ALPHA, color.a);
		if (junk)
			write_reg(tapc_pkg::CFG_IDX_W'($urandom_range(2**tapc_pkg::CFG_IDX_W - 1,
				tapc_pkg::REG_TINT_ALPHA + 1)), tapc_pkg::CFG_DATA_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// hold off until the pipe is empty
	task automatic drain();
		pix_in.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic send_pixel(tapc_pkg::pixel_t s, tapc_pkg::pixel_t d);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			pix_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in.valid <= 1'b1;
		pix_in.src_red <= s.r;
		pix_in.src_green <= s.g;
		pix_in.src_blue <= s.b;
		pix_in.src_alpha <= s.a;
		pix_in.dest_red <= d.r;
		pix_in.dest_green <= d.g;
		pix_in.dest_blue <= d.b;
		pix_in.dest_alpha <= d.a;
		do @(posedge clk); while (!pix_in.ready);
	endtask

	initial begin : result_sink
		int stall;
		pix_out.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 13);
			if (stall != 0) begin
				pix_out.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pix_out.ready <= 1'b1;
			do @(posedge clk); while (!(pix_out.valid && pix_out.ready));
		end
	end

	initial begin : stimulus
		tapc_pkg::pixel_t tint;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		pix_in.valid = 1'b0;
		pix_in.src_red = '0;
		pix_in.src_green = '0;
		pix_in.src_blue = '0;
		pix_in.src_alpha = '0;
		pix_in.dest_red = '0;
		pix_in.dest_green = '0;
		pix_in.dest_blue = '0;
		pix_in.dest_alpha = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: tint off
		send_pixel(pix(0, 0, 0, 0), pix(0, 0, 0, 0));
		send_pixel(pix(255, 255, 255, 255), pix(255, 255, 255, 255));
		send_pixel(pix(255, 255, 255, 0), pix(10, 20, 30, 40));
		send_pixel(pix(200, 100, 50, 255), pix(1, 2, 3, 0));
		send_pixel(pix(90, 180, 45, 200), pix(33, 66, 99, 100));
		send_pixel(pix(255, 0, 255, 128), pix(0, 255, 0, 128));
		drain();

		load_tint(8'hFF, pix(255, 0, 128, 255), 1'b1);
		send_pixel(pix(12, 34, 56, 0), pix(200, 150, 100, 50));
		send_pixel(pix(12, 34, 56, 255), pix(200, 150, 100, 50));
		send_pixel(pix(255, 255, 255, 1), pix(0, 0, 0, 255));
		drain();

		load_tint(8'h01, pix(0, 255, 0, 0), 1'b0);
		send_pixel(pix(70, 140, 210, 255), pix(5, 6, 7, 8));
		send_pixel(pix(70, 140, 210, 100), pix(250, 250, 250, 200));
		drain();

		load_tint(8'h01, pix(17, 230, 99, 200), 1'b1);
		send_pixel(pix(40, 80, 120, 100), pix(160, 60, 20, 50));
		send_pixel(pix(255, 255, 255, 255), pix(0, 0, 0, 0));
		drain();

		// even value: enable bit clears, colour kept
		write_reg(tapc_pkg::REG_TINT_ENABLE, 8'h02);
		cfg_we <= 1'b0;
		send_pixel(pix(40, 80, 120, 77), pix(160, 60, 20, 50));
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			tint = rand_pixel();
			case (phase % 4)
				0: tint.a = '0;
				1: tint.a = '1;
				default: ;
			endcase
			load_tint(tapc_pkg::CFG_DATA_W'($urandom()), tint, 1'($urandom_range(0, 1)));
			calm = (phase % 3 == 1);
			for (int n = 0; n < WORDS_PER_PHASE; n++)
				send_pixel(rand_pixel(), rand_pixel());
			calm = 1'b0;
			drain();
		end

		if (fail_count == 0 && outstanding == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
